// File: design/ldst_pkg.sv
package ldst_pkg;

  // item kinds
  localparam logic [1:0] KIND_TOUCH = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_ROW_Q = 2'd2;
  localparam logic [1:0] KIND_WIN_Q = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROWS_IN_USE    = 1'b0;
  localparam logic CFG_COLUMNS_IN_USE = 1'b1;

  typedef struct packed {
    logic [8:0] rows_in_use;
    logic [8:0] columns_in_use;
  } cfg_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_WALK,
    ENG_DONE
  } eng_state_t;

endpackage

// File: design/ldst_store.sv
module ldst_store #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 256,
  parameter int AW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CW          = $clog2(MAX_COLUMNS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output logic [2*CW-1:0] rdata_o,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  logic [2*CW-1:0] wdata_i,
  output logic            clr_busy_o
);
  import ldst_pkg::*;

  localparam logic [CW-1:0] MARK     = CW'(MAX_COLUMNS);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_ROWS - 1);

  // {first changed column, last changed column} per row
  logic [2*CW-1:0] mem [MAX_ROWS];
  logic [2*CW-1:0] rdata_r;
  logic            clr_busy_r;
  logic [AW-1:0]   clr_addr_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [2*CW-1:0] wr_data;

  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = {MARK, MARK};
    end else begin
      wr_en   = we_i;
      wr_addr = waddr_i;
      wr_data = wdata_i;
    end
  end

  // post-reset sweep, one row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ROW) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_r <= mem[raddr_i];
    end
  end

  assign rdata_o    = rdata_r;
  assign clr_busy_o = clr_busy_r;

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !we_i && !re_i)
    else $error("store access during clearing sweep");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r && clr_addr_r == LAST_ROW |=> !clr_busy_r)
    else $error("clearing sweep did not end at last row");

  a_clear_steps: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r && clr_addr_r != LAST_ROW |=> clr_busy_r)
    else $error("clearing sweep ended early");

endmodule

// File: design/ldst_engine.sv
module ldst_engine #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 256,
  parameter int AW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CW          = $clog2(MAX_COLUMNS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ldst_pkg::cfg_t  cfg_i,
  input  logic            start_i,
  input  logic [1:0]      kind_i,
  input  logic [7:0]      first_row_i,
  input  logic [8:0]      row_count_i,
  input  logic [7:0]      span_start_i,
  input  logic [7:0]      span_end_i,
  input  logic            mark_all_i,
  output logic            idle_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic            res_status_o,
  output logic            res_changed_o,
  output logic            mem_re_o,
  output logic [AW-1:0]   mem_raddr_o,
  input  logic [2*CW-1:0] mem_rdata_i,
  output logic            mem_we_o,
  output logic [AW-1:0]   mem_waddr_o,
  output logic [2*CW-1:0] mem_wdata_o
);
  import ldst_pkg::*;

  localparam logic [CW-1:0] MARK = CW'(MAX_COLUMNS);

  eng_state_t    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [CW-1:0] xs_r, xs_nxt;
  logic [CW-1:0] xe_r, xe_nxt;
  logic          flag_r, flag_nxt;
  logic [9:0]    row_r, row_nxt;
  logic [9:0]    lim_r, lim_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          status_r, status_nxt;
  logic          changed_r, changed_nxt;

  logic [9:0]    run_end;
  logic          run_bad;
  logic          col_bad;
  logic          issue;
  logic [CW-1:0] rd_s, rd_e, new_s, new_e;

  assign run_end = {2'b00, first_row_i} + {1'b0, row_count_i};
  assign run_bad = run_end > {1'b0, cfg_i.rows_in_use};
  assign col_bad = ({1'b0, span_start_i} >= cfg_i.columns_in_use) ||
                   ({1'b0, span_end_i} >= cfg_i.columns_in_use);

  assign rd_s  = mem_rdata_i[2*CW-1:CW];
  assign rd_e  = mem_rdata_i[CW-1:0];
  assign new_s = (rd_s == MARK || rd_s > xs_r) ? xs_r : rd_s;
  assign new_e = (rd_e == MARK || rd_e < xe_r) ? xe_r : rd_e;
  assign issue = (state_r == ENG_WALK) && (row_r < lim_r);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    xs_nxt        = xs_r;
    xe_nxt        = xe_r;
    flag_nxt      = flag_r;
    row_nxt       = row_r;
    lim_nxt       = lim_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    changed_nxt   = changed_r;
    mem_re_o      = 1'b0;
    mem_raddr_o   = AW'(row_r);
    mem_we_o      = 1'b0;
    mem_waddr_o   = AW'(row_r);
    mem_wdata_o   = {MARK, MARK};
    res_valid_o   = 1'b0;

    unique case (state_r)
      ENG_IDLE: begin
        if (start_i) begin
          kind_nxt    = kind_i;
          xs_nxt      = CW'(span_start_i);
          xe_nxt      = CW'(span_end_i);
          flag_nxt    = mark_all_i;
          status_nxt  = 1'b0;
          changed_nxt = 1'b0;
          row_nxt     = {2'b00, first_row_i};
          state_nxt   = ENG_WALK;
          case (kind_i) inside
            KIND_TOUCH, KIND_SET: begin
              lim_nxt = (32'(run_end) > MAX_ROWS) ? 10'(MAX_ROWS) : run_end;
              if (run_bad || (kind_i == KIND_TOUCH && col_bad)) begin
                status_nxt = 1'b1;
                state_nxt  = ENG_DONE;
              end
            end
            KIND_ROW_Q: begin
              if ({1'b0, first_row_i} < cfg_i.rows_in_use && 32'(first_row_i) < MAX_ROWS) begin
                lim_nxt = {2'b00, first_row_i} + 10'd1;
              end else begin
                lim_nxt = {2'b00, first_row_i};
              end
            end
            default: begin
              row_nxt = '0;
              lim_nxt = (32'(cfg_i.rows_in_use) > MAX_ROWS) ? 10'(MAX_ROWS)
                                                             : {1'b0, cfg_i.rows_in_use};
            end
          endcase
        end
      end
      ENG_WALK: begin
        // finish the row read last cycle
        if (pend_r) begin
          if (kind_r == KIND_TOUCH) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pend_addr_r;
            mem_wdata_o = {new_s, new_e};
          end else if (rd_s != MARK || rd_e != MARK) begin
            changed_nxt = 1'b1;
          end
        end
        // start the next row
        if (issue) begin
          row_nxt = row_r + 10'd1;
          if (kind_r == KIND_SET) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(row_r);
            mem_wdata_o = flag_r ? {{CW{1'b0}}, CW'(cfg_i.columns_in_use - 9'd1)}
                                 : {MARK, MARK};
          end else begin
            mem_re_o      = 1'b1;
            pend_nxt      = 1'b1;
            pend_addr_nxt = AW'(row_r);
          end
        end else if (!pend_r) begin
          state_nxt = ENG_DONE;
        end
      end
      ENG_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    xs_r        <= xs_nxt;
    xe_r        <= xe_nxt;
    flag_r      <= flag_nxt;
    row_r       <= row_nxt;
    lim_r       <= lim_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    changed_r   <= changed_nxt;
  end

  assign idle_o        = (state_r == ENG_IDLE);
  assign res_status_o  = status_r;
  assign res_changed_o = changed_r;

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ENG_WALK |-> !mem_we_o && !mem_re_o && !pend_r)
    else $error("store access outside walk");

  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we_o && mem_re_o |-> mem_waddr_o != mem_raddr_o)
    else $error("read and write of the same row in one cycle");

  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ENG_WALK && (kind_r == KIND_ROW_Q || kind_r == KIND_WIN_Q) |-> !mem_we_o)
    else $error("query wrote the store");

  a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ENG_DONE && status_r |-> !changed_r)
    else $error("error result with changed flag");

endmodule

// File: design/line_dirty_span_tracker_top.sv
// Line dirty span tracker: keeps, for every display row, the first and last
// changed column (or an unchanged mark) in one single-port-write, registered-
// read memory of MAX_ROWS entries. After reset a clearing sweep writes the
// unchanged mark to every row; no word is accepted until it ends, while
// configuration writes are taken at any time. Items are handled one at a
// time by a row walker. A span touch reads each row, then writes it back
// while the following row is read; a row set writes each row; a row query
// reads one row (none for a row outside the window); a window query reads
// every row in use; a range error gives its result without any row access.
// The walker returns to idle when its result moves into the output register,
// so the next word is accepted while that result waits to be taken.
// Configuration values are clamped to their legal range and should only be
// written while the block is idle.
module line_dirty_span_tracker_top #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  // input words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_first_row,
  input  logic [8:0] in_row_count,
  input  logic [7:0] in_span_start,
  input  logic [7:0] in_span_end,
  input  logic       in_mark_all,
  // result words
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic       out_is_changed
);
  import ldst_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  // configuration limits: a 9-bit write clamps into 1..min(MAX, 511)
  localparam int ROWS_CAP_I = (MAX_ROWS < 511) ? MAX_ROWS : 511;
  localparam int COLS_CAP_I = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
  localparam logic [8:0] ROWS_CAP   = 9'(ROWS_CAP_I);
  localparam logic [8:0] COLS_CAP   = 9'(COLS_CAP_I);
  localparam logic [8:0] ROWS_RESET = 9'((MAX_ROWS < 256) ? MAX_ROWS : 256);
  localparam logic [8:0] COLS_RESET = 9'((MAX_COLUMNS < 256) ? MAX_COLUMNS : 256);

  cfg_t       cfg_r;
  logic [8:0] rows_nxt, cols_nxt;

  // engine / store wiring
  logic            eng_idle;
  logic            clr_busy;
  logic            accept;
  logic            res_valid, res_ready, res_status, res_changed;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  logic [2*CW-1:0] mem_rdata, mem_wdata;

  // output register
  logic out_valid_r, out_status_r, out_is_changed_r;

  always_comb begin
    rows_nxt = cfg_wdata;
    if (rows_nxt == 9'd0) begin
      rows_nxt = 9'd1;
    end else if (rows_nxt > ROWS_CAP) begin
      rows_nxt = ROWS_CAP;
    end
    cols_nxt = cfg_wdata;
    if (cols_nxt == 9'd0) begin
      cols_nxt = 9'd1;
    end else if (cols_nxt > COLS_CAP) begin
      cols_nxt = COLS_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_in_use    <= ROWS_RESET;
      cfg_r.columns_in_use <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE:    cfg_r.rows_in_use    <= rows_nxt;
        CFG_COLUMNS_IN_USE: cfg_r.columns_in_use <= cols_nxt;
        default:            ;
      endcase
    end
  end

  // a word is taken whenever the walker is free and the sweep is done,
  // even while an earlier result still waits in the output register
  assign in_ready = eng_idle && !clr_busy;
  assign accept   = in_valid && in_ready;

  ldst_engine #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .AW          (AW),
    .CW          (CW)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_i         (cfg_r),
    .start_i       (accept),
    .kind_i        (in_kind),
    .first_row_i   (in_first_row),
    .row_count_i   (in_row_count),
    .span_start_i  (in_span_start),
    .span_end_i    (in_span_end),
    .mark_all_i    (in_mark_all),
    .idle_o        (eng_idle),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_status_o  (res_status),
    .res_changed_o (res_changed),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata)
  );

  ldst_store #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .AW          (AW),
    .CW          (CW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .re_i       (mem_re),
    .raddr_i    (mem_raddr),
    .rdata_o    (mem_rdata),
    .we_i       (mem_we),
    .waddr_i    (mem_waddr),
    .wdata_i    (mem_wdata),
    .clr_busy_o (clr_busy)
  );

  // result slot frees when empty or drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r     <= res_status;
      out_is_changed_r <= res_changed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_is_changed = out_is_changed_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("word accepted during clearing sweep");

  a_cfg_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_r.rows_in_use != 9'd0 && cfg_r.columns_in_use != 9'd0 &&
    cfg_r.rows_in_use <= ROWS_CAP && cfg_r.columns_in_use <= COLS_CAP)
    else $error("configuration outside clamped range");

  a_result_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid_r)
    else $error("result lost on the way to the output register");

endmodule
